>>> src/lss_pkg.sv
// Shared types, constants and helpers of the LCD scanline sequencer.
package lss_pkg;

    // Default frame geometry.
    localparam int LINES_PER_FRAME_DEF = 154;
    localparam int VISIBLE_LINES_DEF   = 144;

    // Phase cycle budgets.
    localparam logic [8:0] CYC_NONE     = 9'd0;
    localparam logic [8:0] CYC_OAM      = 9'd80;
    localparam logic [8:0] CYC_XFER     = 9'd169;
    localparam logic [8:0] CYC_HBLANK   = 9'd207;
    localparam logic [8:0] CYC_LINE     = 9'd456;
    localparam logic [8:0] CYC_VBL_HEAD = 9'd72;
    localparam logic [8:0] CYC_TAIL     = 9'd376;

    // Status mode codes.
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // Source region codes.
    localparam logic [2:0] REG_ROM0  = 3'd0;
    localparam logic [2:0] REG_ROMX  = 3'd1;
    localparam logic [2:0] REG_ERAM  = 3'd2;
    localparam logic [2:0] REG_WRAM0 = 3'd3;
    localparam logic [2:0] REG_WRAMX = 3'd4;
    localparam logic [2:0] REG_NONE  = 3'd5;

    // Register indexes.
    localparam logic CFG_SKIP_RENDER = 1'b0;
    localparam logic CFG_CART_LOADED = 1'b1;

    // Item kinds.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_DMA  = 1'b1;

    localparam logic [15:0] ADDR_BLOCK_MASK = 16'hfff0;
    localparam logic [15:0] BLOCK_BYTES     = 16'h0010;

    // Phase sequence of one queued job.
    typedef enum logic [1:0] {
        PAT_ONE,
        PAT_VBL,
        PAT_LAST,
        PAT_VIS
    } t_pattern;

    // One input request.
    typedef struct packed {
        logic        kind;
        logic        lcd_on;
        logic [7:0]  line_compare;
        logic [3:0]  stat_enables;
        logic        border_mask;
        logic [15:0] dma_source;
        logic [15:0] dma_target;
        logic [7:0]  dma_blocks;
    } t_item;

    // Classified line work handed from front to back.
    typedef struct packed {
        t_pattern    pattern;
        logic [7:0]  line;
        logic [2:0]  st;
        logic [3:0]  en;
        logic [8:0]  cycles;
        logic        irq_first;
        logic        irq_late;
        logic        frame;
        logic        render;
        logic        dma_valid;
        logic [15:0] dma_src;
        logic [12:0] dma_dst;
        logic [2:0]  dma_region;
    } t_job;

    // One phase result.
    typedef struct packed {
        logic [7:0]  line;
        logic [6:0]  status;
        logic [8:0]  cycles;
        logic        irq_vblank;
        logic        irq_lcd;
        logic        frame_done;
        logic        render_line;
        logic        dma_valid;
        logic [15:0] dma_src_addr;
        logic [12:0] dma_dst_offset;
        logic [2:0]  dma_region;
        logic        last;
    } t_result;

    // Memory map region of a DMA source address.
    function automatic logic [2:0] classify(input logic [15:0] a);
        logic [2:0] r;
        begin
            if (a < 16'h4000)      r = REG_ROM0;
            else if (a < 16'h8000) r = REG_ROMX;
            else if (a >= 16'ha000 && a < 16'hc000) r = REG_ERAM;
            else if (a >= 16'hc000 && a < 16'hd000) r = REG_WRAM0;
            else if (a >= 16'hd000 && a < 16'he000) r = REG_WRAMX;
            else r = REG_NONE;
            return r;
        end
    endfunction

endpackage

>>> src/lss_front.sv
// Front end: accepts requests, advances line and DMA state, classifies line work.
module lss_front #(
    parameter int LINES_PER_FRAME = lss_pkg::LINES_PER_FRAME_DEF,
    parameter int VISIBLE_LINES   = lss_pkg::VISIBLE_LINES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic           i_cfg_wdata,
    input  logic           i_valid,
    output logic           o_ready,
    input  lss_pkg::t_item i_item,
    input  logic           i_q_full,
    output logic           o_push,
    output lss_pkg::t_job  o_job
);
    import lss_pkg::*;

    localparam logic [7:0] LINE_LAST = 8'(LINES_PER_FRAME - 1);
    localparam logic [7:0] LINE_VBL  = 8'(VISIBLE_LINES);
    localparam logic [7:0] FRAME_LEN = 8'(LINES_PER_FRAME);

    logic        r_skip_render, r_cart_loaded;
    logic [7:0]  r_cur_line, n_cur_line;
    logic [2:0]  r_stat_low, n_stat_low;
    logic [7:0]  r_off_count, n_off_count;
    logic        r_dma_active, n_dma_active;
    logic        r_dma_first, n_dma_first;
    logic [15:0] r_dma_src, n_dma_src;
    logic [15:0] r_dma_dst, n_dma_dst;
    logic [7:0]  r_dma_left, n_dma_left;
    logic [2:0]  r_dma_region, n_dma_region;

    logic        accept;
    logic [7:0]  ly;
    logic [7:0]  off_inc;
    logic        coin;
    t_job        job;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (i_item.kind == KIND_TICK);
    assign o_job   = job;

    assign ly      = (r_cur_line == LINE_LAST) ? 8'd0 : r_cur_line + 8'd1;
    assign off_inc = r_off_count + 8'd1;
    assign coin    = (i_item.line_compare == ly);

    // Next state and job classification.
    always_comb begin
        n_cur_line   = r_cur_line;
        n_stat_low   = r_stat_low;
        n_off_count  = r_off_count;
        n_dma_active = r_dma_active;
        n_dma_first  = r_dma_first;
        n_dma_src    = r_dma_src;
        n_dma_dst    = r_dma_dst;
        n_dma_left   = r_dma_left;
        n_dma_region = r_dma_region;

        job            = '0;
        job.pattern    = PAT_ONE;
        job.en         = i_item.stat_enables;
        job.dma_region = REG_NONE;

        if (i_item.kind == KIND_DMA) begin
            n_dma_src    = i_item.dma_source & ADDR_BLOCK_MASK;
            n_dma_dst    = i_item.dma_target & ADDR_BLOCK_MASK;
            n_dma_left   = i_item.dma_blocks;
            n_dma_first  = 1'b1;
            n_dma_active = (i_item.dma_blocks != 8'd0);
        end else if (!r_cart_loaded) begin
            // Idle result: current line and status, nothing else.
            job.line   = r_cur_line;
            job.st     = r_stat_low;
            job.cycles = CYC_NONE;
        end else if (!i_item.lcd_on) begin
            n_cur_line  = 8'd0;
            n_stat_low  = 3'd0;
            job.cycles  = CYC_LINE;
            if (off_inc >= FRAME_LEN) begin
                job.frame   = 1'b1;
                n_off_count = 8'd0;
            end else begin
                n_off_count = off_inc;
            end
        end else begin
            n_cur_line = ly;
            job.line   = ly;
            job.frame  = (ly == 8'd0);
            if (ly >= LINE_VBL) begin
                // Vertical blank lines.
                job.st        = {coin, MODE_VBLANK};
                n_stat_low    = {coin, MODE_VBLANK};
                job.irq_first = coin && i_item.stat_enables[3];
                job.irq_late  = i_item.stat_enables[1];
                if (ly == LINE_VBL) begin
                    job.pattern = PAT_VBL;
                end else if (ly == LINE_LAST) begin
                    job.pattern = PAT_LAST;
                end else begin
                    job.cycles = CYC_LINE;
                end
            end else begin
                // Visible line: OAM scan, transfer, horizontal blank.
                job.pattern   = PAT_VIS;
                job.st        = {coin, MODE_HBLANK};
                n_stat_low    = {coin, MODE_HBLANK};
                job.irq_first = (coin && i_item.stat_enables[3]) || i_item.stat_enables[2];
                job.render    = !r_skip_render && !i_item.border_mask;
                if (r_dma_active) begin
                    job.dma_valid  = 1'b1;
                    job.dma_src    = r_dma_src;
                    job.dma_dst    = r_dma_dst[12:0];
                    job.dma_region = r_dma_first ? classify(r_dma_src) : r_dma_region;
                    n_dma_region   = job.dma_region;
                    n_dma_first    = 1'b0;
                    n_dma_src      = (r_dma_src + BLOCK_BYTES) & ADDR_BLOCK_MASK;
                    n_dma_dst      = (r_dma_dst + BLOCK_BYTES) & ADDR_BLOCK_MASK;
                    n_dma_left     = r_dma_left - 8'd1;
                    if (r_dma_left == 8'd1) begin
                        n_dma_active = 1'b0;
                    end
                end else begin
                    job.irq_late = i_item.stat_enables[0];
                end
            end
        end
    end

    // State registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_render <= 1'b0;
            r_cart_loaded <= 1'b0;
            r_cur_line    <= LINE_LAST;
            r_stat_low    <= 3'd0;
            r_off_count   <= 8'd0;
            r_dma_active  <= 1'b0;
            r_dma_first   <= 1'b0;
            r_dma_src     <= 16'd0;
            r_dma_dst     <= 16'd0;
            r_dma_left    <= 8'd0;
            r_dma_region  <= REG_NONE;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SKIP_RENDER: r_skip_render <= i_cfg_wdata;
                    CFG_CART_LOADED: r_cart_loaded <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                r_cur_line   <= n_cur_line;
                r_stat_low   <= n_stat_low;
                r_off_count  <= n_off_count;
                r_dma_active <= n_dma_active;
                r_dma_first  <= n_dma_first;
                r_dma_src    <= n_dma_src;
                r_dma_dst    <= n_dma_dst;
                r_dma_left   <= n_dma_left;
                r_dma_region <= n_dma_region;
            end
        end
    end

endmodule

>>> src/lss_queue.sv
// Two-entry job queue between the front and back ends.
module lss_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lss_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output lss_pkg::t_job o_job
);
    import lss_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> src/lss_back.sv
// Back end: expands each job into its phase results behind an output register.
module lss_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  lss_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output lss_pkg::t_result o_result
);
    import lss_pkg::*;

    logic [1:0] r_phase;
    logic       r_valid;
    t_result    r_result;
    t_result    res;
    logic       load;

    assign load     = !i_q_empty && (!r_valid || i_ready);
    assign o_pop    = load && res.last;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Result of the current phase.
    always_comb begin
        res            = '0;
        res.line       = i_job.line;
        res.status     = {i_job.en, i_job.st};
        res.dma_region = REG_NONE;
        case (i_job.pattern)
            PAT_ONE: begin
                res.cycles     = i_job.cycles;
                res.irq_lcd    = i_job.irq_first;
                res.frame_done = i_job.frame;
                res.last       = 1'b1;
            end
            PAT_VBL, PAT_LAST: begin
                if (r_phase == 2'd0) begin
                    res.cycles     = (i_job.pattern == PAT_VBL) ? CYC_VBL_HEAD : CYC_OAM;
                    res.irq_lcd    = i_job.irq_first;
                    res.frame_done = i_job.frame;
                end else begin
                    res.cycles = CYC_TAIL;
                    res.last   = 1'b1;
                    if (i_job.pattern == PAT_VBL) begin
                        res.irq_vblank = 1'b1;
                        res.irq_lcd    = i_job.irq_late;
                    end else begin
                        res.line = 8'd0;
                    end
                end
            end
            default: begin
                case (r_phase)
                    2'd0: begin
                        res.status[1:0] = MODE_OAM;
                        res.cycles      = CYC_OAM;
                        res.irq_lcd     = i_job.irq_first;
                        res.frame_done  = i_job.frame;
                    end
                    2'd1: begin
                        res.status[1:0] = MODE_XFER;
                        res.cycles      = CYC_XFER;
                    end
                    default: begin
                        res.status[1:0] = MODE_HBLANK;
                        res.cycles      = CYC_HBLANK;
                        res.render_line = i_job.render;
                        res.irq_lcd     = i_job.irq_late;
                        res.last        = 1'b1;
                        if (i_job.dma_valid) begin
                            res.dma_valid      = 1'b1;
                            res.dma_src_addr   = i_job.dma_src;
                            res.dma_dst_offset = i_job.dma_dst;
                            res.dma_region     = i_job.dma_region;
                        end
                    end
                endcase
            end
        endcase
    end

    // Phase counter and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= res.last ? 2'd0 : r_phase + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= res;
        end
    end

endmodule

>>> src/lcd_scanline_sequencer.sv
// Top level of the LCD scanline sequencer: front end, job queue and back end.
//
// Usage: requests arrive on i_valid/o_ready. A tick request (kind 0) advances
// the scanline and yields one to three phase results on o_valid/i_ready; the
// final one of each request has o_last set. A DMA start request (kind 1) arms
// the HBlank block transfer and yields no result. Configuration is written
// through i_cfg_we/i_cfg_idx/i_cfg_wdata while the block is idle.
// The first result of a tick passes through the job queue and then the
// output register. The back end emits one result per cycle while a job is
// queued and the receiver is not stalling; a tick yields one result per phase
// (three on visible lines, two on the vertical blank start and last lines,
// one otherwise), which sets the sustained rate. The two-entry job queue
// lets requests in while earlier results go out or wait on the receiver.
// Reset puts the line counter on the last line so the first tick starts a
// frame at line 0; DMA is idle and both configuration bits clear.
// When the receiver stalls, the result register holds, the queue fills and
// o_ready drops until room frees up.
module lcd_scanline_sequencer #(
    parameter int LINES_PER_FRAME = lss_pkg::LINES_PER_FRAME_DEF,
    parameter int VISIBLE_LINES   = lss_pkg::VISIBLE_LINES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic        i_lcd_on,
    input  logic [7:0]  i_line_compare,
    input  logic [3:0]  i_stat_enables,
    input  logic        i_border_mask,
    input  logic [15:0] i_dma_source,
    input  logic [15:0] i_dma_target,
    input  logic [7:0]  i_dma_blocks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_line,
    output logic [6:0]  o_status,
    output logic [8:0]  o_cycles,
    output logic        o_irq_vblank,
    output logic        o_irq_lcd,
    output logic        o_frame_done,
    output logic        o_render_line,
    output logic        o_dma_valid,
    output logic [15:0] o_dma_src_addr,
    output logic [12:0] o_dma_dst_offset,
    output logic [2:0]  o_dma_region,
    output logic        o_last
);
    import lss_pkg::*;

    t_item   item;
    t_job    push_job, head_job;
    t_result result;
    logic    q_full, q_empty, push, pop;

    assign item = '{
        kind:         i_kind,
        lcd_on:       i_lcd_on,
        line_compare: i_line_compare,
        stat_enables: i_stat_enables,
        border_mask:  i_border_mask,
        dma_source:   i_dma_source,
        dma_target:   i_dma_target,
        dma_blocks:   i_dma_blocks
    };

    lss_front #(
        .LINES_PER_FRAME(LINES_PER_FRAME),
        .VISIBLE_LINES  (VISIBLE_LINES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (item),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    lss_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (q_full),
        .o_empty(q_empty),
        .i_pop  (pop),
        .o_job  (head_job)
    );

    lss_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    // Result fields onto their ports.
    assign o_line           = result.line;
    assign o_status         = result.status;
    assign o_cycles         = result.cycles;
    assign o_irq_vblank     = result.irq_vblank;
    assign o_irq_lcd        = result.irq_lcd;
    assign o_frame_done     = result.frame_done;
    assign o_render_line    = result.render_line;
    assign o_dma_valid      = result.dma_valid;
    assign o_dma_src_addr   = result.dma_src_addr;
    assign o_dma_dst_offset = result.dma_dst_offset;
    assign o_dma_region     = result.dma_region;
    assign o_last           = result.last;

endmodule

>>> verif/tb.sv
// Testbench of the LCD scanline sequencer: directed and random requests checked by a scoreboard.
`timescale 1ns / 100ps

import lss_pkg::*;

// Predicts the phase results of each accepted request and checks the block's output.
class phase_scoreboard;
    localparam int          LINES       = LINES_PER_FRAME_DEF;
    localparam int          VISIBLE     = VISIBLE_LINES_DEF;
    localparam logic [12:0] VRAM_OFS_MASK = 13'h1ff0;

    // Configuration and line state as the block should hold them.
    logic        skip_render;
    logic        cart_loaded;
    logic [7:0]  cur_line;
    logic [2:0]  stat_low;
    logic [7:0]  off_count;
    logic        dma_on;
    logic        dma_first;
    logic [15:0] dma_src;
    logic [15:0] dma_dst;
    logic [7:0]  dma_left;
    logic [2:0]  dma_region;

    t_result expected_phases[$];
    int      errors;

    function new();
        skip_render = 1'b0;
        cart_loaded = 1'b0;
        cur_line    = 8'(LINES - 1);
        stat_low    = 3'd0;
        off_count   = 8'd0;
        dma_on      = 1'b0;
        dma_first   = 1'b0;
        dma_src     = 16'd0;
        dma_dst     = 16'd0;
        dma_left    = 8'd0;
        dma_region  = REG_NONE;
        errors      = 0;
    endfunction

    function void set_config(logic idx, logic val);
        if (idx == CFG_SKIP_RENDER) begin
            skip_render = val;
        end else begin
            cart_loaded = val;
        end
    endfunction

    function logic [7:0] next_line();
        return 8'((int'(cur_line) + 1) % LINES);
    endfunction

    function int pending();
        return expected_phases.size();
    endfunction

    // Memory map region of a transfer source.
    function logic [2:0] source_region(logic [15:0] a);
        if (a < 16'h4000) return REG_ROM0;
        if (a < 16'h8000) return REG_ROMX;
        if (a >= 16'ha000 && a < 16'hc000) return REG_ERAM;
        if (a >= 16'hc000 && a < 16'hd000) return REG_WRAM0;
        if (a >= 16'hd000 && a < 16'he000) return REG_WRAMX;
        return REG_NONE;
    endfunction

    // A phase with every flag clear and no block transfer.
    function t_result blank_phase(logic [7:0] line, logic [6:0] status, logic [8:0] cycles);
        t_result r;
        r            = '0;
        r.line       = line;
        r.status     = status;
        r.cycles     = cycles;
        r.dma_region = REG_NONE;
        return r;
    endfunction

    // Works out the phases that one accepted request causes.
    function void note_request(t_item it);
        t_result    r;
        logic [3:0] en;
        logic [7:0] ly;
        logic       coinc;
        logic       irq_first;
        logic       frame;
        en = it.stat_enables;

        // A transfer start replaces any running transfer and gives no phase.
        if (it.kind == KIND_DMA) begin
            dma_src   = it.dma_source & ADDR_BLOCK_MASK;
            dma_dst   = it.dma_target & ADDR_BLOCK_MASK;
            dma_left  = it.dma_blocks;
            dma_first = 1'b1;
            dma_on    = (it.dma_blocks != 8'd0);
            return;
        end

        // Without a cartridge a tick only reports the current line.
        if (!cart_loaded) begin
            r      = blank_phase(cur_line, {en, stat_low}, CYC_NONE);
            r.last = 1'b1;
            expected_phases.push_back(r);
            return;
        end

        // Display off: a full idle line, and a frame every LINES such ticks.
        if (!it.lcd_on) begin
            cur_line  = 8'd0;
            stat_low  = 3'd0;
            off_count = off_count + 8'd1;
            frame     = (off_count >= 8'(LINES));
            if (frame) begin
                off_count = 8'd0;
            end
            r            = blank_phase(8'd0, {en, 3'd0}, CYC_LINE);
            r.frame_done = frame;
            r.last       = 1'b1;
            expected_phases.push_back(r);
            return;
        end

        ly        = next_line();
        cur_line  = ly;
        coinc     = (it.line_compare == ly);
        irq_first = coinc & en[3];
        frame     = (ly == 8'd0);

        if (ly >= 8'(VISIBLE)) begin
            stat_low = {coinc, MODE_VBLANK};
            if (ly == 8'(VISIBLE)) begin
                // Vertical blank starts: short head, then the interrupt phase.
                r            = blank_phase(ly, {en, stat_low}, CYC_VBL_HEAD);
                r.irq_lcd    = irq_first;
                r.frame_done = frame;
                expected_phases.push_back(r);
                r            = blank_phase(ly, {en, stat_low}, CYC_TAIL);
                r.irq_vblank = 1'b1;
                r.irq_lcd    = en[1];
                r.last       = 1'b1;
                expected_phases.push_back(r);
            end else if (ly == 8'(LINES - 1)) begin
                // The last line shows line zero for its tail.
                r            = blank_phase(ly, {en, stat_low}, CYC_OAM);
                r.irq_lcd    = irq_first;
                r.frame_done = frame;
                expected_phases.push_back(r);
                r      = blank_phase(8'd0, {en, stat_low}, CYC_TAIL);
                r.last = 1'b1;
                expected_phases.push_back(r);
            end else begin
                r            = blank_phase(ly, {en, stat_low}, CYC_LINE);
                r.irq_lcd    = irq_first;
                r.frame_done = frame;
                r.last       = 1'b1;
                expected_phases.push_back(r);
            end
        end else begin
            // Visible line: OAM search, pixel transfer, then horizontal blank.
            r            = blank_phase(ly, {en, coinc, MODE_OAM}, CYC_OAM);
            r.irq_lcd    = irq_first | en[2];
            r.frame_done = frame;
            expected_phases.push_back(r);
            r = blank_phase(ly, {en, coinc, MODE_XFER}, CYC_XFER);
            expected_phases.push_back(r);
            r             = blank_phase(ly, {en, coinc, MODE_HBLANK}, CYC_HBLANK);
            r.render_line = !skip_render && !it.border_mask;
            if (dma_on) begin
                // A transfer line moves one block and skips the HBlank interrupt.
                if (dma_first) begin
                    dma_region = source_region(dma_src);
                    dma_first  = 1'b0;
                end
                r.dma_valid      = 1'b1;
                r.dma_src_addr   = dma_src;
                r.dma_dst_offset = dma_dst[12:0] & VRAM_OFS_MASK;
                r.dma_region     = dma_region;
                dma_src  = (dma_src + BLOCK_BYTES) & ADDR_BLOCK_MASK;
                dma_dst  = (dma_dst + BLOCK_BYTES) & ADDR_BLOCK_MASK;
                dma_left = dma_left - 8'd1;
                if (dma_left == 8'd0) begin
                    dma_on = 1'b0;
                end
            end else begin
                r.irq_lcd = en[0];
            end
            r.last   = 1'b1;
            stat_low = {coinc, MODE_HBLANK};
            expected_phases.push_back(r);
        end
    endfunction

    function void cmp_field(string name, int unsigned exp, int unsigned got);
        if (exp != got) begin
            $error("%s: expected %0d, actual %0d", name, exp, got);
            errors++;
        end
    endfunction

    // Compares an accepted phase with the oldest expected one.
    function void check_phase(t_result got);
        t_result exp;
        if (expected_phases.size() == 0) begin
            $error("phase result with none expected: line %0d cycles %0d",
                   got.line, got.cycles);
            errors++;
            return;
        end
        exp = expected_phases.pop_front();
        cmp_field("line", 32'(exp.line), 32'(got.line));
        cmp_field("status", 32'(exp.status), 32'(got.status));
        cmp_field("cycles", 32'(exp.cycles), 32'(got.cycles));
        cmp_field("irq_vblank", 32'(exp.irq_vblank), 32'(got.irq_vblank));
        cmp_field("irq_lcd", 32'(exp.irq_lcd), 32'(got.irq_lcd));
        cmp_field("frame_done", 32'(exp.frame_done), 32'(got.frame_done));
        cmp_field("render_line", 32'(exp.render_line), 32'(got.render_line));
        cmp_field("dma_valid", 32'(exp.dma_valid), 32'(got.dma_valid));
        cmp_field("dma_src_addr", 32'(exp.dma_src_addr), 32'(got.dma_src_addr));
        cmp_field("dma_dst_offset", 32'(exp.dma_dst_offset), 32'(got.dma_dst_offset));
        cmp_field("dma_region", 32'(exp.dma_region), 32'(got.dma_region));
        cmp_field("last", 32'(exp.last), 32'(got.last));
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;

    typedef enum int {
        GEN_ON,
        GEN_OFF,
        GEN_NOISE
    } t_gen;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_idx      = 1'b0;
    logic        i_cfg_wdata    = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_kind         = 1'b0;
    logic        i_lcd_on       = 1'b0;
    logic [7:0]  i_line_compare = 8'd0;
    logic [3:0]  i_stat_enables = 4'd0;
    logic        i_border_mask  = 1'b0;
    logic [15:0] i_dma_source   = 16'd0;
    logic [15:0] i_dma_target   = 16'd0;
    logic [7:0]  i_dma_blocks   = 8'd0;
    logic        i_ready        = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_line;
    logic [6:0]  o_status;
    logic [8:0]  o_cycles;
    logic        o_irq_vblank;
    logic        o_irq_lcd;
    logic        o_frame_done;
    logic        o_render_line;
    logic        o_dma_valid;
    logic [15:0] o_dma_src_addr;
    logic [12:0] o_dma_dst_offset;
    logic [2:0]  o_dma_region;
    logic        o_last;

    t_result         out_phase;
    phase_scoreboard sb;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              hold_cycles    = 0;
    int              cycle_count    = 0;

    lcd_scanline_sequencer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_kind           (i_kind),
        .i_lcd_on         (i_lcd_on),
        .i_line_compare   (i_line_compare),
        .i_stat_enables   (i_stat_enables),
        .i_border_mask    (i_border_mask),
        .i_dma_source     (i_dma_source),
        .i_dma_target     (i_dma_target),
        .i_dma_blocks     (i_dma_blocks),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_line           (o_line),
        .o_status         (o_status),
        .o_cycles         (o_cycles),
        .o_irq_vblank     (o_irq_vblank),
        .o_irq_lcd        (o_irq_lcd),
        .o_frame_done     (o_frame_done),
        .o_render_line    (o_render_line),
        .o_dma_valid      (o_dma_valid),
        .o_dma_src_addr   (o_dma_src_addr),
        .o_dma_dst_offset (o_dma_dst_offset),
        .o_dma_region     (o_dma_region),
        .o_last           (o_last)
    );

    assign out_phase = {o_line, o_status, o_cycles, o_irq_vblank, o_irq_lcd, o_frame_done,
                        o_render_line, o_dma_valid, o_dma_src_addr, o_dma_dst_offset,
                        o_dma_region, o_last};

    // Clock.
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is asked for.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_phase(out_phase);
        end
    end

    function automatic t_item mk(logic kind, logic lcd_on, logic [7:0] cmp, logic [3:0] en,
                                 logic mask, logic [15:0] src, logic [15:0] dst,
                                 logic [7:0] blocks);
        t_item it;
        it.kind         = kind;
        it.lcd_on       = lcd_on;
        it.line_compare = cmp;
        it.stat_enables = en;
        it.border_mask  = mask;
        it.dma_source   = src;
        it.dma_target   = dst;
        it.dma_blocks   = blocks;
        return it;
    endfunction

    // Random request; the mode decides how often the display is on.
    function automatic t_item rand_item(t_gen gen);
        t_item it;
        case (gen)
            GEN_ON: begin
                it.kind   = ($urandom_range(9) == 0) ? KIND_DMA : KIND_TICK;
                it.lcd_on = 1'b1;
            end
            GEN_OFF: begin
                it.kind   = ($urandom_range(19) == 0) ? KIND_DMA : KIND_TICK;
                it.lcd_on = ($urandom_range(15) == 0);
            end
            default: begin
                it.kind   = 1'($urandom_range(1));
                it.lcd_on = 1'($urandom_range(1));
            end
        endcase
        it.line_compare = ($urandom_range(3) == 0) ? sb.next_line() : 8'($urandom_range(255));
        it.stat_enables = 4'($urandom_range(15));
        it.border_mask  = ($urandom_range(3) == 0);
        it.dma_source   = 16'($urandom_range(16'hffff));
        it.dma_target   = 16'($urandom_range(16'hffff));
        it.dma_blocks   = ($urandom_range(9) == 0) ? 8'($urandom_range(128, 1))
                                                   : 8'($urandom_range(6, 1));
        return it;
    endfunction

    // Offers one request, waits for it to be taken, then maybe idles.
    task automatic send_request(t_item it);
        i_valid        <= 1'b1;
        i_kind         <= it.kind;
        i_lcd_on       <= it.lcd_on;
        i_line_compare <= it.line_compare;
        i_stat_enables <= it.stat_enables;
        i_border_mask  <= it.border_mask;
        i_dma_source   <= it.dma_source;
        i_dma_target   <= it.dma_target;
        i_dma_blocks   <= it.dma_blocks;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Stops offering and waits until every expected phase has come out.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_config(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends random requests until enough of the kind that matters have gone.
    task automatic run_phase(t_gen gen, int needed, int hold_at, int pause_at);
        t_item it;
        int    counted;
        int    sent;
        counted = 0;
        sent    = 0;
        while (counted < needed) begin
            it = rand_item(gen);
            send_request(it);
            sent++;
            if (gen == GEN_NOISE || (it.kind == KIND_TICK && (gen == GEN_OFF) != it.lcd_on)) begin
                counted++;
            end
            if (sent == hold_at) begin
                hold_cycles = HOLD_CYCLES;
            end
            if (sent == pause_at) begin
                drain();
            end
        end
        drain();
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ticks without a cartridge report the reset line.
        send_request(mk(KIND_TICK, 1'b1, 8'd153, 4'hf, 1'b0, 16'h0000, 16'h0000, 8'd1));
        send_request(mk(KIND_TICK, 1'b0, 8'd0, 4'h0, 1'b1, 16'hffff, 16'hffff, 8'd128));
        drain();
        write_cfg(CFG_CART_LOADED, 1'b1);

        // Directed: frame start, coincidence, transfers from all regions but ROMX, cancel.
        send_request(mk(KIND_DMA, 1'b0, 8'd0, 4'h0, 1'b0, 16'hffff, 16'hffff, 8'd2));
        send_request(mk(KIND_TICK, 1'b1, 8'd0, 4'hf, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_TICK, 1'b1, 8'd255, 4'h0, 1'b1, 16'h1234, 16'h5678, 8'd9));
        send_request(mk(KIND_TICK, 1'b1, 8'd7, 4'h1, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_DMA, 1'b1, 8'd0, 4'h0, 1'b0, 16'h0000, 16'h0000, 8'd128));
        send_request(mk(KIND_TICK, 1'b1, 8'd4, 4'h8, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_DMA, 1'b1, 8'd0, 4'h0, 1'b0, 16'h4000, 16'h8000, 8'd0));
        send_request(mk(KIND_TICK, 1'b1, 8'd0, 4'h1, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_DMA, 1'b0, 8'd0, 4'h0, 1'b0, 16'ha000, 16'h9ff0, 8'd1));
        send_request(mk(KIND_TICK, 1'b1, 8'd7, 4'h3, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_DMA, 1'b0, 8'd0, 4'h0, 1'b0, 16'hc000, 16'h8010, 8'd1));
        send_request(mk(KIND_TICK, 1'b1, 8'd8, 4'hc, 1'b1, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_DMA, 1'b0, 8'd0, 4'h0, 1'b0, 16'hd00f, 16'h1fff, 8'd1));
        send_request(mk(KIND_TICK, 1'b1, 8'd0, 4'h0, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_DMA, 1'b0, 8'd0, 4'h0, 1'b0, 16'h7fff, 16'h0000, 8'd1));
        send_request(mk(KIND_DMA, 1'b0, 8'd0, 4'h0, 1'b0, 16'hbff0, 16'hfff0, 8'd3));
        send_request(mk(KIND_TICK, 1'b1, 8'd0, 4'h4, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_TICK, 1'b0, 8'd0, 4'hf, 1'b0, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_TICK, 1'b0, 8'd0, 4'h5, 1'b1, 16'h0000, 16'h0000, 8'd0));
        send_request(mk(KIND_TICK, 1'b1, 8'd1, 4'h8, 1'b0, 16'h0000, 16'h0000, 8'd0));
        drain();

        // A whole frame of display-on ticks with no idling, a long hold-off and a pause.
        run_phase(GEN_ON, 154, 30, 100);

        // Display mostly off with an idle sender and rendering skipped.
        send_idle_pct = 82;
        write_cfg(CFG_SKIP_RENDER, 1'b1);
        run_phase(GEN_OFF, 12, -1, -1);

        // Noise with a stalling receiver, first without a cartridge.
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        write_cfg(CFG_CART_LOADED, 1'b0);
        run_phase(GEN_NOISE, 10, -1, -1);
        write_cfg(CFG_CART_LOADED, 1'b1);
        write_cfg(CFG_SKIP_RENDER, 1'b0);
        run_phase(GEN_NOISE, 12, -1, -1);

        // Display-on ticks with light idling on both sides and rendering skipped.
        send_idle_pct  = 12;
        recv_stall_pct = 12;
        write_cfg(CFG_SKIP_RENDER, 1'b1);
        run_phase(GEN_ON, 10, -1, -1);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
